### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the set engine
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  `ASSERT_CLK(label, clk, rst, !(cond))

`endif

### design/sus_pkg.sv
// ----------------------------------------------------------------------------
// sus_pkg
// types and codes shared by the sorted set engine
// ----------------------------------------------------------------------------
package sus_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ERASE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOCHANGE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] vertex;
    logic [5:0]  rank;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [6:0]  element_count;
  } rsp_t;

  typedef struct packed {
    logic ins_en;
    logic del_en;
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

### design/sus_stream_if.sv
// ----------------------------------------------------------------------------
// sus_stream_if
// valid/ready channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface sus_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### design/sus_cell.sv
// ----------------------------------------------------------------------------
// sus_cell
// one storage cell of the sorted row: compares, then shifts with neighbors
// ----------------------------------------------------------------------------
module sus_cell #(
  parameter int W   = 32,
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 capture,
  input  logic [W-1:0]         probe,
  input  logic [5:0]           rank,
  input  logic [CW-1:0]        count,
  input  logic [W-1:0]         key,
  input  sus_pkg::cell_ctl_t   ctl,
  input  logic                 prev_lt,
  input  logic [W-1:0]         prev_elem,
  input  logic [W-1:0]         next_elem,
  output logic [W-1:0]         elem,
  output logic                 lt,
  output logic                 eq,
  output logic [W-1:0]         rd
);

  logic occupied;
  logic hit;

  assign occupied = CW'(IDX) < count;
  assign hit      = (IDX < 64) && (6'(IDX) == rank);

  always_ff @(posedge clk) begin
    if (capture) begin
      lt <= occupied && (elem < probe);
      eq <= occupied && (elem == probe);
      rd <= hit ? elem : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins_en) begin
      if (!lt) begin
        elem <= prev_lt ? key : prev_elem;
      end
    end else if (ctl.del_en) begin
      if (!lt) begin
        elem <= next_elem;
      end
    end
  end

endmodule

### design/sus_ctrl.sv
// ----------------------------------------------------------------------------
// sus_ctrl
// command sequencing, element count and result register
// ----------------------------------------------------------------------------
module sus_ctrl #(
  parameter int CAP = 64,
  parameter int W   = 32,
  parameter int CW  = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  sus_stream_if.sink              cmd,
  sus_stream_if.source            rsp,
  input  logic [CAP-1:0]          eq_vec,
  input  logic [CAP-1:0][W-1:0]   rd_vec,
  output logic                    capture,
  output logic [W-1:0]            probe,
  output logic [5:0]              rank,
  output logic [W-1:0]            key,
  output logic [CW-1:0]           count,
  output sus_pkg::cell_ctl_t      ctl
);

  localparam int RW = (CW > 6 ? CW : 6) + 1;

  sus_pkg::state_t state, state_next;
  logic [1:0]      op;
  logic [5:0]      rd_rank;
  logic [CW-1:0]   count_next;
  logic            exec_go;
  logic            found;
  logic            full;
  logic            in_range;
  logic [W-1:0]    rd_or;
  logic [1:0]      status;
  logic [W-1:0]    value;
  logic            rsp_valid;
  sus_pkg::rsp_t   rsp_data;

  assign probe   = cmd.payload.vertex[W-1:0];
  assign rank    = cmd.payload.rank;
  assign capture = cmd.valid && cmd.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sus_pkg::S_IDLE: if (capture) state_next = sus_pkg::S_EXEC;
      sus_pkg::S_EXEC: if (exec_go) state_next = sus_pkg::S_IDLE;
      default:         state_next = sus_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.ready = 1'b0;
    exec_go   = 1'b0;
    unique case (state)
      sus_pkg::S_IDLE: cmd.ready = 1'b1;
      sus_pkg::S_EXEC: exec_go = !rsp_valid || rsp.ready;
      default:         cmd.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sus_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      op      <= cmd.payload.opcode;
      rd_rank <= cmd.payload.rank;
      key     <= probe;
    end
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAP; i++) begin
      rd_or = rd_or | rd_vec[i];
    end
  end

  assign found    = |eq_vec;
  assign full     = count >= CW'(CAP);
  assign in_range = (RW'(rd_rank) < RW'(count)) && (RW'(rd_rank) < RW'(CAP));

  always_comb begin
    status     = sus_pkg::ST_NOCHANGE;
    value      = '0;
    count_next = count;
    ctl        = '{default: 1'b0};
    unique case (op)
      sus_pkg::OP_INSERT: begin
        if (found) begin
          status = sus_pkg::ST_NOCHANGE;
        end else if (full) begin
          status = sus_pkg::ST_FULL;
        end else begin
          status     = sus_pkg::ST_OK;
          count_next = count + 1'b1;
          ctl.ins_en = exec_go;
        end
      end
      sus_pkg::OP_ERASE: begin
        if (found) begin
          status     = sus_pkg::ST_OK;
          count_next = count - 1'b1;
          ctl.del_en = exec_go;
        end
      end
      sus_pkg::OP_READ: begin
        if (in_range) begin
          status = sus_pkg::ST_OK;
          value  = rd_or;
        end else begin
          status = sus_pkg::ST_RANGE;
        end
      end
      default: status = sus_pkg::ST_NOCHANGE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (exec_go) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      rsp_data.status        <= status;
      rsp_data.read_value    <= 32'(value);
      rsp_data.element_count <= 7'(count_next);
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_data;

endmodule

### design/sorted_unique_set_engine.sv
// one command at a time: the next transfer is taken once the last result is registered
// at transfer every cell compares its entry with the vertex, then in the execute state the row shifts
// a result held in the output register does not block the next command transfer
// reset clears the element count, the sequencer and the result valid
// stored entries are undefined after reset and need no clearing pass
// ----------------------------------------------------------------------------
// sorted_unique_set_engine
// ascending set of distinct vertex identifiers held in a row of shift cells
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_unique_set_engine #(
  parameter int SET_CAPACITY = 64,
  parameter int VERTEX_BITS  = 32
) (
  input  logic         clk,
  input  logic         rst,
  sus_stream_if.sink   cmd,
  sus_stream_if.source rsp
);

  localparam int W  = VERTEX_BITS < 32 ? VERTEX_BITS : 32;
  localparam int CW = $clog2(SET_CAPACITY + 1);

  logic                            capture;
  logic [W-1:0]                    probe;
  logic [5:0]                      rank;
  logic [W-1:0]                    key;
  logic [CW-1:0]                   count;
  sus_pkg::cell_ctl_t              ctl;
  logic [SET_CAPACITY-1:0]         lt_vec;
  logic [SET_CAPACITY-1:0]         eq_vec;
  logic [SET_CAPACITY-1:0][W-1:0]  rd_vec;
  logic [SET_CAPACITY-1:0][W-1:0]  elem;

  sus_ctrl #(
    .CAP (SET_CAPACITY),
    .W   (W),
    .CW  (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rsp     (rsp),
    .eq_vec  (eq_vec),
    .rd_vec  (rd_vec),
    .capture (capture),
    .probe   (probe),
    .rank    (rank),
    .key     (key),
    .count   (count),
    .ctl     (ctl)
  );

  for (genvar i = 0; i < SET_CAPACITY; i++) begin : g_cell
    logic         prev_lt;
    logic [W-1:0] prev_elem;
    logic [W-1:0] next_elem;

    if (i == 0) begin : g_first
      assign prev_lt   = 1'b1;
      assign prev_elem = key;
    end else begin : g_mid
      assign prev_lt   = lt_vec[i-1];
      assign prev_elem = elem[i-1];
    end

    if (i == SET_CAPACITY - 1) begin : g_last
      assign next_elem = '0;
    end else begin : g_inner
      assign next_elem = elem[i+1];
    end

    sus_cell #(
      .W   (W),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .capture   (capture),
      .probe     (probe),
      .rank      (rank),
      .count     (count),
      .key       (key),
      .ctl       (ctl),
      .prev_lt   (prev_lt),
      .prev_elem (prev_elem),
      .next_elem (next_elem),
      .elem      (elem[i]),
      .lt        (lt_vec[i]),
      .eq        (eq_vec[i]),
      .rd        (rd_vec[i])
    );
  end

  `ASSERT_NEVER(a_ins_del_excl, clk, rst, ctl.ins_en && ctl.del_en)
  `ASSERT_NEVER(a_count_bound, clk, rst, count > CW'(SET_CAPACITY))
  `ASSERT_CLK(a_ins_not_full, clk, rst, ctl.ins_en |-> (count < CW'(SET_CAPACITY)))
  `ASSERT_CLK(a_ins_grows, clk, rst, ctl.ins_en |=> (count == CW'($past(count) + 1'b1)))
  `ASSERT_CLK(a_del_shrinks, clk, rst, ctl.del_en |=> (count == CW'($past(count) - 1'b1)))

endmodule
